// File: hdl/sparse_nonzero_statistics_core_defines.svh
// assertion macros shared by the sparse nonzero statistics modules
`ifndef SPARSE_NONZERO_STATISTICS_CORE_DEFINES_SVH
`define SPARSE_NONZERO_STATISTICS_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SNZS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SNZS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/snzs_pkg.sv
// shared types and constants of the sparse nonzero statistics core
package snzs_pkg;

    localparam int VAL_W     = 17;
    localparam int AVG_W     = 25;
    localparam int ROWC_W    = 17;
    localparam int COLC_W    = 13;
    localparam int NZC_W     = 17;
    localparam int FRAC_BITS = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 120;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int DIV_CNT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NONZERO_COUNT = 2'd2;

    localparam logic MODE_PTR = 1'b0;
    localparam logic MODE_COL = 1'b1;

    localparam logic [VAL_W-1:0] COUNT_CEIL = 17'h1FFFF;

    // what the back part does with a queued request
    typedef enum logic [1:0] {
        KIND_PTR,
        KIND_COL,
        KIND_SKIP
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_item;

    // first member lands in the highest bits
    typedef struct packed {
        logic [AVG_W-1:0] col_average;
        logic [VAL_W-1:0] col_max;
        logic [VAL_W-1:0] col_min;
        logic [AVG_W-1:0] row_average;
        logic [VAL_W-1:0] row_max;
        logic [VAL_W-1:0] row_min;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SCAN,
        ST_DIV_ROW,
        ST_DIV_COL,
        ST_OUT
    } t_state;

endpackage

// File: hdl/snzs_ram.sv
// generic single-write, single-read ram with registered read data
module snzs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/snzs_front.sv
// front part: takes requests and classifies them for the back part
module snzs_front #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                        i_valid,
    input  logic                        i_mode,
    input  logic [snzs_pkg::VAL_W-1:0]  i_value,
    input  logic                        i_last,
    output logic                        o_ready,
    input  logic [snzs_pkg::COLC_W-1:0] i_col_count,
    input  logic                        i_clearing,
    input  logic                        i_q_full,
    output logic                        o_push,
    output snzs_pkg::t_item             o_item
);
    import snzs_pkg::*;

    localparam logic [VAL_W:0] LP_MAX_COLS = (VAL_W + 1)'(MAX_COLUMNS);

    logic in_range;

    // hold off while the queue is full or the histogram is being cleared
    assign o_ready = !i_q_full && !i_clearing;
    assign o_push  = i_valid && o_ready;

    // column index must lie below both the configured and the built column count
    assign in_range = (i_value < VAL_W'(i_col_count)) && ({1'b0, i_value} < LP_MAX_COLS);

    // classify the request
    always_comb begin
        o_item.value = i_value;
        o_item.last  = i_last;
        if (i_mode == MODE_PTR) begin
            o_item.kind = KIND_PTR;
        end else if (in_range) begin
            o_item.kind = KIND_COL;
        end else begin
            o_item.kind = KIND_SKIP;
        end
    end

endmodule

// File: hdl/snzs_queue.sv
// short request queue between the front and back parts
`include "sparse_nonzero_statistics_core_defines.svh"
module snzs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  snzs_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output snzs_pkg::t_item o_item,
    output logic            o_empty
);
    import snzs_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SNZS_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "queue overflow")
    `SNZS_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "queue underflow")
    `SNZS_ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue level lost a request")

endmodule

// File: hdl/snzs_div.sv
// iterative restoring divider, one quotient bit per cycle
module snzs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [snzs_pkg::AVG_W-1:0]  i_dividend,
    input  logic [snzs_pkg::ROWC_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [snzs_pkg::AVG_W-1:0]  o_quotient
);
    import snzs_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LP_LAST_STEP = DIV_CNT_W'(AVG_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [ROWC_W-1:0]     r_dvs;
    logic [ROWC_W-1:0]     r_rem;
    logic [AVG_W-1:0]      r_quo;
    logic [ROWC_W:0]       rem_sh;
    logic                  fits;

    // one restoring step; a zero divisor yields all ones
    assign rem_sh = {r_rem, r_quo[AVG_W-1]};
    assign fits   = (rem_sh >= {1'b0, r_dvs});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LP_LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LP_LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? ROWC_W'(rem_sh - {1'b0, r_dvs}) : ROWC_W'(rem_sh);
            r_quo <= {r_quo[AVG_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hdl/snzs_back.sv
// back part: row statistics, column histogram, final scan and averages
`include "sparse_nonzero_statistics_core_defines.svh"
module snzs_back #(
    parameter int MAX_COLUMNS  = 4096,
    parameter int MAX_NONZEROS = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [snzs_pkg::ROWC_W-1:0] i_row_count,
    input  logic [snzs_pkg::COLC_W-1:0] i_col_count,
    input  logic [snzs_pkg::NZC_W-1:0]  i_nonzero_count,
    input  snzs_pkg::t_item             i_item,
    input  logic                        i_q_empty,
    output logic                        o_pop,
    output logic                        o_clearing,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output snzs_pkg::t_result           o_result
);
    import snzs_pkg::*;

    localparam int AW = $clog2(MAX_COLUMNS);
    localparam logic [AW-1:0] LP_LAST_ADDR = AW'(MAX_COLUMNS - 1);
    localparam logic [VAL_W-1:0] LP_LIMIT =
        (MAX_NONZEROS < 131071) ? VAL_W'(MAX_NONZEROS) : COUNT_CEIL;

    t_state r_state, n_state;

    // scan / clear address
    logic [AW-1:0]    r_scan_addr, n_scan_addr;
    logic             scan_last;

    // histogram read stage
    logic             r_b_valid, n_b_valid;
    logic             r_b_scan,  n_b_scan;
    logic             r_b_first, n_b_first;
    logic             r_b_incl,  n_b_incl;
    logic [AW-1:0]    r_b_addr,  n_b_addr;

    // last histogram write, for forwarding
    logic             r_w_valid;
    logic [AW-1:0]    r_w_addr;
    logic [VAL_W-1:0] r_w_data;

    // ram port
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;
    logic [VAL_W-1:0] cnt_cur;

    // row statistics
    logic [VAL_W-1:0] r_prev, n_prev;
    logic [1:0]       r_seen, n_seen;
    logic [VAL_W-1:0] r_row_min, n_row_min;
    logic [VAL_W-1:0] r_row_max, n_row_max;
    logic [VAL_W-1:0] row_len;

    // column statistics and averages
    logic [VAL_W-1:0] r_col_min, n_col_min;
    logic [VAL_W-1:0] r_col_max, n_col_max;
    logic [AVG_W-1:0] r_row_avg, n_row_avg;
    logic [AVG_W-1:0] r_col_avg, n_col_avg;

    // result register
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    // fsm outputs
    logic             pop;
    logic             clear_wr;
    logic             scan_rd;
    logic             div_start;
    logic             div_sel_col;
    logic             out_load;
    logic             div_done;
    logic [AVG_W-1:0] div_quo;

    assign scan_last = (r_scan_addr == LP_LAST_ADDR);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (scan_last) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (!i_q_empty && i_item.last) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_last) n_state = ST_DIV_ROW;
            end
            ST_DIV_ROW: begin
                if (div_done) n_state = ST_DIV_COL;
            end
            ST_DIV_COL: begin
                if (div_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) n_state = ST_RUN;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // fsm outputs
    always_comb begin
        pop         = 1'b0;
        clear_wr    = 1'b0;
        scan_rd     = 1'b0;
        div_start   = 1'b0;
        div_sel_col = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                clear_wr = 1'b1;
            end
            ST_RUN: begin
                pop = !i_q_empty;
            end
            ST_SCAN: begin
                scan_rd   = 1'b1;
                div_start = scan_last;
            end
            ST_DIV_ROW: begin
                div_start   = div_done;
                div_sel_col = 1'b1;
            end
            ST_DIV_COL: begin
            end
            ST_OUT: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    assign o_pop      = pop;
    assign o_clearing = (r_state == ST_CLEAR);

    // histogram memory
    assign cnt_cur   = (r_w_valid && (r_w_addr == r_b_addr)) ? r_w_data : ram_rdata;
    assign ram_raddr = scan_rd ? r_scan_addr : i_item.value[AW-1:0];
    assign ram_we    = clear_wr || r_b_valid;
    assign ram_waddr = clear_wr ? r_scan_addr : r_b_addr;
    always_comb begin
        if (clear_wr || r_b_scan) begin
            ram_wdata = '0;
        end else if (cnt_cur < LP_LIMIT) begin
            ram_wdata = cnt_cur + 1'b1;
        end else begin
            ram_wdata = cnt_cur;
        end
    end

    snzs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_COLUMNS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared divider for both averages
    snzs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({i_nonzero_count, {FRAC_BITS{1'b0}}}),
        .i_divisor  (div_sel_col ? ROWC_W'(i_col_count) : i_row_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign row_len = (i_item.value >= r_prev) ? (i_item.value - r_prev) : '0;

    // datapath next values
    always_comb begin
        n_scan_addr = r_scan_addr;
        if (clear_wr || scan_rd) begin
            n_scan_addr = scan_last ? '0 : r_scan_addr + 1'b1;
        end

        n_b_valid = (pop && (i_item.kind == KIND_COL)) || scan_rd;
        n_b_scan  = scan_rd;
        n_b_first = (r_scan_addr == '0);
        n_b_incl  = (VAL_W'(r_scan_addr) < VAL_W'(i_col_count));
        n_b_addr  = ram_raddr;

        n_prev    = r_prev;
        n_seen    = r_seen;
        n_row_min = r_row_min;
        n_row_max = r_row_max;
        if (pop && (i_item.kind == KIND_PTR)) begin
            n_prev = i_item.value;
            n_seen = (r_seen == 2'd0) ? 2'd1 : 2'd2;
            if (r_seen == 2'd1) begin
                n_row_min = row_len;
                n_row_max = row_len;
            end else if (r_seen == 2'd2) begin
                if (row_len < r_row_min) n_row_min = row_len;
                if (row_len > r_row_max) n_row_max = row_len;
            end
        end

        // column min and max over the included part of the scan
        n_col_min = r_col_min;
        n_col_max = r_col_max;
        if (pop && i_item.last) begin
            n_col_min = '0;
            n_col_max = '0;
        end else if (r_b_valid && r_b_scan && r_b_incl) begin
            if (r_b_first) begin
                n_col_min = cnt_cur;
                n_col_max = cnt_cur;
            end else begin
                if (cnt_cur < r_col_min) n_col_min = cnt_cur;
                if (cnt_cur > r_col_max) n_col_max = cnt_cur;
            end
        end

        n_row_avg = r_row_avg;
        n_col_avg = r_col_avg;
        if (div_done && (r_state == ST_DIV_ROW)) n_row_avg = div_quo;
        if (div_done && (r_state == ST_DIV_COL)) n_col_avg = div_quo;

        // result register, then clear the per-matrix row state
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (out_load) begin
            n_out_valid       = 1'b1;
            n_out.row_min     = r_row_min;
            n_out.row_max     = r_row_max;
            n_out.row_average = r_row_avg;
            n_out.col_min     = r_col_min;
            n_out.col_max     = r_col_max;
            n_out.col_average = r_col_avg;
            n_prev    = '0;
            n_seen    = 2'd0;
            n_row_min = '0;
            n_row_max = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_scan_addr <= '0;
            r_b_valid   <= 1'b0;
            r_w_valid   <= 1'b0;
            r_seen      <= 2'd0;
            r_prev      <= '0;
            r_row_min   <= '0;
            r_row_max   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_addr <= n_scan_addr;
            r_b_valid   <= n_b_valid;
            r_w_valid   <= ram_we;
            r_seen      <= n_seen;
            r_prev      <= n_prev;
            r_row_min   <= n_row_min;
            r_row_max   <= n_row_max;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_b_scan  <= n_b_scan;
        r_b_first <= n_b_first;
        r_b_incl  <= n_b_incl;
        r_b_addr  <= n_b_addr;
        r_w_addr  <= ram_waddr;
        r_w_data  <= ram_wdata;
        r_col_min <= n_col_min;
        r_col_max <= n_col_max;
        r_row_avg <= n_row_avg;
        r_col_avg <= n_col_avg;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `SNZS_ASSERT_IMPL(a_inc_follows_pop, i_clk, i_rst_n, r_b_valid && !r_b_scan, r_state == ST_RUN || r_state == ST_SCAN, "histogram increment outside run")
    `SNZS_ASSERT_IMPL(a_row_order, i_clk, i_rst_n, r_seen == 2'd2, r_row_min <= r_row_max, "row minimum above maximum")
    `SNZS_ASSERT_IMPL(a_div_in_seq, i_clk, i_rst_n, div_done, r_state == ST_DIV_ROW || r_state == ST_DIV_COL, "divider finished outside division")

endmodule

// File: hdl/sparse_nonzero_statistics_core.sv
// top level: per-matrix row and column nonzero statistics of a csr stream
// pointer and column requests: one per cycle while tready is high, each held in the queue until the back part pops it
// last request: result follows the one-entry-per-cycle histogram scan and two 25-step
//   divisions in one shared divider
// throughput: one request per cycle outside that final scan, division and result hand-off, while tready is high
// reset (synchronous, active low): histogram clearing pass over all MAX_COLUMNS entries, tready low
module sparse_nonzero_statistics_core #(
    parameter int MAX_COLUMNS  = 4096,
    parameter int MAX_NONZEROS = 65536
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [snzs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [snzs_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [snzs_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // value[16:0], zero pad
    input  logic                                 s_axis_tuser,  // mode[0]
    input  logic                                 s_axis_tlast,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // row_min[16:0], row_max[33:17], row_average[58:34], col_min[75:59],
    // col_max[92:76], col_average[117:93], zero pad
    output logic [snzs_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import snzs_pkg::*;

    logic [ROWC_W-1:0] r_row_count;
    logic [COLC_W-1:0] r_col_count;
    logic [NZC_W-1:0]  r_nonzero_count;

    logic    q_push, q_pop, q_full, q_empty, clearing;
    t_item   front_item, q_item;
    t_result result;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count     <= ROWC_W'(1);
            r_col_count     <= COLC_W'(1);
            r_nonzero_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_COUNT:     r_row_count     <= i_cfg_data[ROWC_W-1:0];
                CFG_COL_COUNT:     r_col_count     <= i_cfg_data[COLC_W-1:0];
                CFG_NONZERO_COUNT: r_nonzero_count <= i_cfg_data[NZC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    snzs_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_valid     (s_axis_tvalid),
        .i_mode      (s_axis_tuser),
        .i_value     (s_axis_tdata[VAL_W-1:0]),
        .i_last      (s_axis_tlast),
        .o_ready     (s_axis_tready),
        .i_col_count (r_col_count),
        .i_clearing  (clearing),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_item      (front_item)
    );

    snzs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    snzs_back #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_NONZEROS (MAX_NONZEROS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_row_count     (r_row_count),
        .i_col_count     (r_col_count),
        .i_nonzero_count (r_nonzero_count),
        .i_item          (q_item),
        .i_q_empty       (q_empty),
        .o_pop           (q_pop),
        .o_clearing      (clearing),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_result        (result)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, result};

endmodule
